[sv/tolerance_cluster_accumulator_unit_defines.svh]
// Assertion macros shared by the tolerance cluster accumulator RTL.
`ifndef TOLERANCE_CLUSTER_ACCUMULATOR_UNIT_DEFINES_SVH
`define TOLERANCE_CLUSTER_ACCUMULATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tca: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tca: next-cycle check failed");

`endif

[sv/tca_pkg.sv]
// Types, widths and codes of the tolerance cluster accumulator.
package tca_pkg;

    localparam int FUNC_W   = 2;
    localparam int SERIES_W = 4;
    localparam int COORD_W  = 20;
    localparam int RIDX_W   = 6;
    localparam int TOL_W    = 19;
    localparam int COUNT_W  = 16;
    localparam int SUM_W    = 36;
    localparam int OFILL_W  = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_TOL = 2'd1;

    // 1.1875 in Q15.4.
    localparam logic [TOL_W-1:0] TOL_RESET = 19'd19;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos;
        logic signed [COORD_W-1:0] value;
        logic [COUNT_W-1:0]        count;
        logic signed [SUM_W-1:0]   sum;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [RIDX_W-1:0]         entry_index;
        logic                      hit;
        logic                      dropped;
        logic                      entry_valid;
        logic signed [COORD_W-1:0] entry_pos;
        logic signed [COORD_W-1:0] entry_value;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [SUM_W-1:0]   entry_sum;
        logic [OFILL_W-1:0]        fill_count;
    } result_t;

    // Absolute difference of two signed coordinates, one bit wider.
    function automatic logic [COORD_W:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? (~d + 1'b1) : d;
    endfunction

    // Sum plus a sample value, clamped to the signed sum range.
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]   s,
        input logic signed [COORD_W-1:0] v
    );
        logic [SUM_W:0] t;
        t = {s[SUM_W-1], s} + {{(SUM_W + 1 - COORD_W){v[COORD_W-1]}}, v};
        if (t[SUM_W] != t[SUM_W-1])
        begin
            return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return t[SUM_W-1:0];
    endfunction

endpackage

[sv/tca_cmd_if.sv]
// Command channel: one item per push, read or clear request.
interface tca_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [tca_pkg::FUNC_W-1:0]          func;
    logic [tca_pkg::SERIES_W-1:0]        series;
    logic signed [tca_pkg::COORD_W-1:0]  sample_pos;
    logic signed [tca_pkg::COORD_W-1:0]  sample_value;
    logic [tca_pkg::RIDX_W-1:0]          read_index;

    modport source (
        output valid, func, series, sample_pos, sample_value, read_index,
        input  ready
    );
    modport sink (
        input  valid, func, series, sample_pos, sample_value, read_index,
        output ready
    );
endinterface

[sv/tca_rsp_if.sv]
// Response channel: one result item per command item.
interface tca_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [tca_pkg::RIDX_W-1:0]          entry_index;
    logic                                hit;
    logic                                dropped;
    logic                                entry_valid;
    logic signed [tca_pkg::COORD_W-1:0]  entry_pos;
    logic signed [tca_pkg::COORD_W-1:0]  entry_value;
    logic [tca_pkg::COUNT_W-1:0]         entry_count;
    logic signed [tca_pkg::SUM_W-1:0]    entry_sum;
    logic [tca_pkg::OFILL_W-1:0]         fill_count;

    modport source (
        output valid, entry_index, hit, dropped, entry_valid, entry_pos, entry_value,
               entry_count, entry_sum, fill_count,
        input  ready
    );
    modport sink (
        input  valid, entry_index, hit, dropped, entry_valid, entry_pos, entry_value,
               entry_count, entry_sum, fill_count,
        output ready
    );
endinterface

[sv/tca_cfg_if.sv]
// Configuration write channel: register index and write data.
interface tca_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tca_pkg::CFG_IDX_W-1:0]   index;
    logic [tca_pkg::TOL_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/tca_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/tolerance_cluster_accumulator_unit.sv]
// Tolerance cluster accumulator: one cluster table per series, held in an entry RAM.
// Each series owns ENTRIES consecutive slots of one entry RAM; a push scans the valid
// entries of its series one per cycle, lowest index first, through the single read
// port of that RAM, merges the sample into the first entry within both tolerances or
// appends a new entry, and flags the sample as dropped when the table is full. A push
// reads the fill count, scans at most that many entries, then writes back a merge or
// an append; a read fetches the fill count and then the entry, skipping the entry read
// when the index lies at or beyond the fill count; a clear or unused code 3 needs only
// the fill count read, and an out-of-range series goes straight to the finishing state.
// Each item waits in its finishing state while the previous result is still held in
// the output register. Fill counts live in a small RAM with one valid flag per series,
// so no clearing pass is needed after reset. One item is worked on at a time; a finished
// result waits in the output register while the next item is accepted, and the command
// channel is ready again in the same cycle as the result appears.
`include "tolerance_cluster_accumulator_unit_defines.svh"

module tolerance_cluster_accumulator_unit #(
    parameter int SERIES  = 16,
    parameter int ENTRIES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    tca_cfg_if.sink   cfg,
    tca_cmd_if.sink   cmd,
    tca_rsp_if.source rsp
);

    localparam int SER_W  = (SERIES > 1) ? $clog2(SERIES) : 1;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int DEPTH  = SERIES * ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (FILL_W > tca_pkg::RIDX_W) ? FILL_W : tca_pkg::RIDX_W;
    localparam logic [FILL_W-1:0] ENTRIES_F = FILL_W'(ENTRIES);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FILL_RD = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_UPDATE  = 3'd3;
    localparam logic [2:0] ST_APPEND  = 3'd4;
    localparam logic [2:0] ST_RD_WAIT = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    logic [2:0]                         state_reg, state_next;
    logic [tca_pkg::FUNC_W-1:0]         func_reg, func_next;
    logic [SER_W-1:0]                   series_reg, series_next;
    logic signed [tca_pkg::COORD_W-1:0] pos_reg, pos_next;
    logic signed [tca_pkg::COORD_W-1:0] val_reg, val_next;
    logic [tca_pkg::RIDX_W-1:0]         ridx_reg, ridx_next;
    logic [ADDR_W-1:0]                  base_reg, base_next;
    logic [FILL_W-1:0]                  fill_reg, fill_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    tca_pkg::entry_t                    ent_reg, ent_next;
    tca_pkg::result_t                   res_reg, res_next;
    tca_pkg::result_t                   out_reg, out_next;
    logic                               out_valid_reg, out_valid_next;
    logic [tca_pkg::TOL_W-1:0]          pos_tol_reg, pos_tol_next;
    logic [tca_pkg::TOL_W-1:0]          val_tol_reg, val_tol_next;
    logic [SERIES-1:0]                  fill_vld_reg, fill_vld_next;

    logic                               ent_we, ent_re;
    logic [ADDR_W-1:0]                  ent_waddr, ent_raddr;
    tca_pkg::entry_t                    ent_wdata, ent_rd;
    logic [tca_pkg::ENTRY_W-1:0]        ent_rdata;

    logic                               fill_we, fill_re;
    logic [SER_W-1:0]                   fill_waddr, fill_raddr;
    logic [FILL_W-1:0]                  fill_wdata, fill_rdata;

    logic [5:0]                         ser_ext;
    logic [SER_W-1:0]                   cmd_ser;
    logic                               ser_ok;
    logic [FILL_W-1:0]                  fill_now;
    logic [FILL_W-1:0]                  idx_inc;
    logic                               match;
    tca_pkg::entry_t                    upd;

    assign ent_rd  = tca_pkg::entry_t'(ent_rdata);
    assign ser_ext = {2'b00, cmd.series};
    assign cmd_ser = ser_ext[SER_W-1:0];
    assign ser_ok  = {3'b000, cmd.series} < 7'(SERIES);

    assign fill_now = fill_vld_reg[series_reg] ? fill_rdata : '0;
    assign idx_inc  = FILL_W'(idx_reg) + FILL_W'(1);

    assign match = (tca_pkg::abs_diff(pos_reg, ent_rd.pos) <= {2'b00, pos_tol_reg})
                && (tca_pkg::abs_diff(val_reg, ent_rd.value) <= {2'b00, val_tol_reg});

    always_comb
    begin
        upd       = ent_reg;
        upd.sum   = tca_pkg::sat_add(ent_reg.sum, val_reg);
        if (ent_reg.count != tca_pkg::COUNT_MAX)
        begin
            upd.count = ent_reg.count + 1'b1;
        end
    end

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        series_next    = series_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        ridx_next      = ridx_reg;
        base_next      = base_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        ent_next       = ent_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        pos_tol_next   = pos_tol_reg;
        val_tol_next   = val_tol_reg;
        fill_vld_next  = fill_vld_reg;

        ent_we     = 1'b0;
        ent_re     = 1'b0;
        ent_waddr  = base_reg + ADDR_W'(idx_reg);
        ent_raddr  = base_reg;
        ent_wdata  = upd;
        fill_we    = 1'b0;
        fill_re    = 1'b0;
        fill_waddr = series_reg;
        fill_raddr = cmd_ser;
        fill_wdata = fill_reg + FILL_W'(1);

        if (cfg.valid)
        begin
            case (cfg.index)
                tca_pkg::CFG_POS_TOL: pos_tol_next = cfg.data;
                tca_pkg::CFG_VAL_TOL: val_tol_next = cfg.data;
                default: ;
            endcase
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next   = cmd.func;
                    series_next = cmd_ser;
                    pos_next    = cmd.sample_pos;
                    val_next    = cmd.sample_value;
                    ridx_next   = cmd.read_index;
                    base_next   = ADDR_W'(cmd_ser * ENTRIES);
                    if (ser_ok)
                    begin
                        fill_re    = 1'b1;
                        state_next = ST_FILL_RD;
                    end
                    else
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FILL_RD:
            begin
                fill_next = fill_now;
                idx_next  = '0;
                res_next  = '0;
                case (func_reg)
                    tca_pkg::FUNC_PUSH:
                    begin
                        if (fill_now == '0)
                        begin
                            state_next = ST_APPEND;
                        end
                        else
                        begin
                            ent_re     = 1'b1;
                            ent_raddr  = base_reg;
                            state_next = ST_SCAN;
                        end
                    end
                    tca_pkg::FUNC_READ:
                    begin
                        if (CMP_W'(ridx_reg) < CMP_W'(fill_now))
                        begin
                            ent_re     = 1'b1;
                            ent_raddr  = base_reg + ADDR_W'(ridx_reg);
                            state_next = ST_RD_WAIT;
                        end
                        else
                        begin
                            res_next.entry_index = ridx_reg;
                            res_next.fill_count  = tca_pkg::OFILL_W'(fill_now);
                            state_next           = ST_DONE;
                        end
                    end
                    tca_pkg::FUNC_CLEAR:
                    begin
                        fill_vld_next[series_reg] = 1'b0;
                        state_next                = ST_DONE;
                    end
                    default:
                    begin
                        res_next.fill_count = tca_pkg::OFILL_W'(fill_now);
                        state_next          = ST_DONE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    ent_next   = ent_rd;
                    state_next = ST_UPDATE;
                end
                else if (idx_inc == fill_reg)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    // Fetch the next entry while this one is being compared.
                    ent_re    = 1'b1;
                    ent_raddr = base_reg + ADDR_W'(idx_inc);
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                ent_we     = 1'b1;
                ent_waddr  = base_reg + ADDR_W'(idx_reg);
                ent_wdata  = upd;
                res_next             = '0;
                res_next.entry_index = tca_pkg::RIDX_W'(idx_reg);
                res_next.hit         = 1'b1;
                res_next.entry_valid = 1'b1;
                res_next.entry_pos   = upd.pos;
                res_next.entry_value = upd.value;
                res_next.entry_count = upd.count;
                res_next.entry_sum   = upd.sum;
                res_next.fill_count  = tca_pkg::OFILL_W'(fill_reg);
                state_next           = ST_DONE;
            end
            ST_APPEND:
            begin
                res_next = '0;
                if (fill_reg >= ENTRIES_F)
                begin
                    res_next.dropped    = 1'b1;
                    res_next.fill_count = tca_pkg::OFILL_W'(fill_reg);
                end
                else
                begin
                    ent_we          = 1'b1;
                    ent_waddr       = base_reg + ADDR_W'(fill_reg);
                    ent_wdata.pos   = pos_reg;
                    ent_wdata.value = val_reg;
                    ent_wdata.count = tca_pkg::COUNT_W'(1);
                    ent_wdata.sum   = tca_pkg::SUM_W'(val_reg);
                    fill_we         = 1'b1;
                    fill_waddr      = series_reg;
                    fill_wdata      = fill_reg + FILL_W'(1);
                    fill_vld_next[series_reg] = 1'b1;
                    res_next.entry_index = tca_pkg::RIDX_W'(fill_reg);
                    res_next.entry_valid = 1'b1;
                    res_next.entry_pos   = pos_reg;
                    res_next.entry_value = val_reg;
                    res_next.entry_count = tca_pkg::COUNT_W'(1);
                    res_next.entry_sum   = tca_pkg::SUM_W'(val_reg);
                    res_next.fill_count  = tca_pkg::OFILL_W'(fill_reg + FILL_W'(1));
                end
                state_next = ST_DONE;
            end
            ST_RD_WAIT:
            begin
                res_next             = '0;
                res_next.entry_index = ridx_reg;
                res_next.entry_valid = 1'b1;
                res_next.entry_pos   = ent_rd.pos;
                res_next.entry_value = ent_rd.value;
                res_next.entry_count = ent_rd.count;
                res_next.entry_sum   = ent_rd.sum;
                res_next.fill_count  = tca_pkg::OFILL_W'(fill_reg);
                state_next           = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pos_tol_reg   <= tca_pkg::TOL_RESET;
            val_tol_reg   <= tca_pkg::TOL_RESET;
            fill_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_tol_reg   <= pos_tol_next;
            val_tol_reg   <= val_tol_next;
            fill_vld_reg  <= fill_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        series_reg <= series_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        ridx_reg   <= ridx_next;
        base_reg   <= base_next;
        fill_reg   <= fill_next;
        idx_reg    <= idx_next;
        ent_reg    <= ent_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    tca_ram #(
        .WIDTH (tca_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    tca_ram #(
        .WIDTH (FILL_W),
        .DEPTH (SERIES)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (fill_re),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.entry_index = out_reg.entry_index;
    assign rsp.hit         = out_reg.hit;
    assign rsp.dropped     = out_reg.dropped;
    assign rsp.entry_valid = out_reg.entry_valid;
    assign rsp.entry_pos   = out_reg.entry_pos;
    assign rsp.entry_value = out_reg.entry_value;
    assign rsp.entry_count = out_reg.entry_count;
    assign rsp.entry_sum   = out_reg.entry_sum;
    assign rsp.fill_count  = out_reg.fill_count;

    // The entry RAM is never read and written at the same slot in one cycle.
    `TCA_ASSERT_IMP(a_no_rw_overlap, clk, rst_n, ent_we && ent_re, ent_waddr != ent_raddr)
    // A result reaches the output register only from the finishing state.
    `TCA_ASSERT_IMP(a_out_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_DONE)
    // The scan never runs past the filled part of the table.
    `TCA_ASSERT_IMP(a_scan_in_fill, clk, rst_n, state_reg == ST_SCAN, FILL_W'(idx_reg) < fill_reg)
    // A merge always writes back to the entry it read.
    `TCA_ASSERT_NXT(a_update_writes, clk, rst_n, state_reg == ST_SCAN && match, ent_we)

endmodule

[tb/sv/tb_tolerance_cluster_accumulator_unit.sv]
// Self-checking testbench of the tolerance cluster accumulator with its own cluster table model.
module tb_tolerance_cluster_accumulator_unit;

    localparam int SERIES  = 16;
    localparam int ENTRIES = 64;
    localparam int SLOTS   = SERIES * ENTRIES;

    localparam logic [tca_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam int COORD_MAX = 524287;
    localparam int COORD_MIN = -524288;
    localparam int unsigned TOL_MAX = 524287;

    localparam longint SUM_HI = 64'sd34359738367;
    localparam longint SUM_LO = -64'sd34359738368;

    localparam int MERGE_PUSHES = 4;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 75;
    localparam int SETTLE_TICKS = ENTRIES + 16;

    logic clk;
    logic rst_n;

    tca_cfg_if cfg();
    tca_cmd_if cmd();
    tca_rsp_if rsp();

    tolerance_cluster_accumulator_unit #(
        .SERIES  (SERIES),
        .ENTRIES (ENTRIES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // Cluster table model, updated as each command item is accepted.
    logic [tca_pkg::TOL_W-1:0]          pos_tol = tca_pkg::TOL_RESET;
    logic [tca_pkg::TOL_W-1:0]          val_tol = tca_pkg::TOL_RESET;
    logic signed [tca_pkg::COORD_W-1:0] ref_pos     [SLOTS];
    logic signed [tca_pkg::COORD_W-1:0] ref_val     [SLOTS];
    logic [tca_pkg::COUNT_W-1:0]        merge_count [SLOTS];
    logic signed [tca_pkg::SUM_W-1:0]   value_sum   [SLOTS];
    int                                 fill        [SERIES];

    tca_pkg::result_t pending_results[$];
    int               mismatches = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic tca_pkg::result_t with_entry(tca_pkg::result_t r, int slot);
        r.entry_valid = 1'b1;
        r.entry_pos   = ref_pos[slot];
        r.entry_value = ref_val[slot];
        r.entry_count = merge_count[slot];
        r.entry_sum   = value_sum[slot];
        return r;
    endfunction

    function automatic tca_pkg::result_t cluster_step(
        input logic [tca_pkg::FUNC_W-1:0]         func,
        input logic [tca_pkg::SERIES_W-1:0]       series,
        input logic signed [tca_pkg::COORD_W-1:0] pos,
        input logic signed [tca_pkg::COORD_W-1:0] value,
        input logic [tca_pkg::RIDX_W-1:0]         ridx
    );
        tca_pkg::result_t r;
        int      base;
        int      n;
        int      slot;
        longint  dp;
        longint  dv;
        longint  s;
        r = '0;
        base = int'(series) * ENTRIES;
        n = fill[series];
        r.fill_count = tca_pkg::OFILL_W'(n);
        case (func)
            tca_pkg::FUNC_PUSH:
            begin
                for (int i = 0; i < n; i++)
                begin
                    slot = base + i;
                    dp = longint'(pos) - longint'(ref_pos[slot]);
                    dv = longint'(value) - longint'(ref_val[slot]);
                    if (dp < 0)
                        dp = -dp;
                    if (dv < 0)
                        dv = -dv;
                    if (dp <= longint'(pos_tol) && dv <= longint'(val_tol))
                    begin
                        s = longint'(value_sum[slot]) + longint'(value);
                        if (s > SUM_HI)
                            s = SUM_HI;
                        if (s < SUM_LO)
                            s = SUM_LO;
                        value_sum[slot] = s[tca_pkg::SUM_W-1:0];
                        if (merge_count[slot] != tca_pkg::COUNT_MAX)
                            merge_count[slot] = merge_count[slot] + 1'b1;
                        r.entry_index = tca_pkg::RIDX_W'(i);
                        r.hit = 1'b1;
                        return with_entry(r, slot);
                    end
                end
                if (n >= ENTRIES)
                begin
                    r.dropped = 1'b1;
                    return r;
                end
                slot = base + n;
                ref_pos[slot]     = pos;
                ref_val[slot]     = value;
                merge_count[slot] = tca_pkg::COUNT_W'(1);
                value_sum[slot]   = tca_pkg::SUM_W'(value);
                fill[series]      = n + 1;
                r.entry_index     = tca_pkg::RIDX_W'(n);
                r.fill_count      = tca_pkg::OFILL_W'(n + 1);
                r = with_entry(r, slot);
            end
            tca_pkg::FUNC_READ:
            begin
                r.entry_index = ridx;
                if (int'(ridx) < n)
                    r = with_entry(r, base + int'(ridx));
            end
            tca_pkg::FUNC_CLEAR:
            begin
                fill[series] = 0;
                r.fill_count = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void note_mismatch(
        input string  what,
        input longint want,
        input longint got
    );
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    // Result checker: every accepted result is compared with the oldest prediction.
    initial
    begin
        tca_pkg::result_t seen;
        tca_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                seen.entry_index = rsp.entry_index;
                seen.hit         = rsp.hit;
                seen.dropped     = rsp.dropped;
                seen.entry_valid = rsp.entry_valid;
                seen.entry_pos   = rsp.entry_pos;
                seen.entry_value = rsp.entry_value;
                seen.entry_count = rsp.entry_count;
                seen.entry_sum   = rsp.entry_sum;
                seen.fill_count  = rsp.fill_count;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result item with nothing expected: index %0d fill %0d",
                                 seen.entry_index, seen.fill_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen.entry_index !== want.entry_index)
                        note_mismatch("entry_index", longint'(want.entry_index),
                                      longint'(seen.entry_index));
                    if (seen.hit !== want.hit)
                        note_mismatch("hit", longint'(want.hit), longint'(seen.hit));
                    if (seen.dropped !== want.dropped)
                        note_mismatch("dropped", longint'(want.dropped),
                                      longint'(seen.dropped));
                    if (seen.entry_valid !== want.entry_valid)
                        note_mismatch("entry_valid", longint'(want.entry_valid),
                                      longint'(seen.entry_valid));
                    if (seen.entry_pos !== want.entry_pos)
                        note_mismatch("entry_pos", longint'(want.entry_pos),
                                      longint'(seen.entry_pos));
                    if (seen.entry_value !== want.entry_value)
                        note_mismatch("entry_value", longint'(want.entry_value),
                                      longint'(seen.entry_value));
                    if (seen.entry_count !== want.entry_count)
                        note_mismatch("entry_count", longint'(want.entry_count),
                                      longint'(seen.entry_count));
                    if (seen.entry_sum !== want.entry_sum)
                        note_mismatch("entry_sum", longint'(want.entry_sum),
                                      longint'(seen.entry_sum));
                    if (seen.fill_count !== want.fill_count)
                        note_mismatch("fill_count", longint'(want.fill_count),
                                      longint'(seen.fill_count));
                end
            end
        end
    end

    // Result side back-pressure: a random stall before each result item.
    initial
    begin
        int stall;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, 7);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!(rsp.valid && rsp.ready));
        end
    end

    task automatic send_cmd(
        input logic [tca_pkg::FUNC_W-1:0] func,
        input int                         series,
        input int                         pos,
        input int                         value,
        input int                         ridx
    );
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.func         <= func;
        cmd.series       <= tca_pkg::SERIES_W'(series);
        cmd.sample_pos   <= tca_pkg::COORD_W'(pos);
        cmd.sample_value <= tca_pkg::COORD_W'(value);
        cmd.read_index   <= tca_pkg::RIDX_W'(ridx);
        cmd.valid        <= 1'b1;
        do @(posedge clk); while (!(cmd.valid && cmd.ready));
        pending_results.push_back(cluster_step(func, tca_pkg::SERIES_W'(series),
                                               tca_pkg::COORD_W'(pos),
                                               tca_pkg::COORD_W'(value),
                                               tca_pkg::RIDX_W'(ridx)));
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain();
        cmd.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_tolerances(input int unsigned ptol, input int unsigned vtol);
        cfg.index <= tca_pkg::CFG_POS_TOL;
        cfg.data  <= tca_pkg::TOL_W'(ptol);
        cfg.valid <= 1'b1;
        do @(posedge clk); while (!(cfg.valid && cfg.ready));
        pos_tol = tca_pkg::TOL_W'(ptol);
        cfg.index <= tca_pkg::CFG_VAL_TOL;
        cfg.data  <= tca_pkg::TOL_W'(vtol);
        do @(posedge clk); while (!(cfg.valid && cfg.ready));
        val_tol = tca_pkg::TOL_W'(vtol);
        cfg.valid <= 1'b0;
    endtask

    function automatic int clamp_coord(input int v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic int random_coord();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 1048575)) + COORD_MIN;
            1: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            default: return int'($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    // A coordinate within or just beyond the tolerance around a stored reference.
    function automatic int near(input int center, input int unsigned tol);
        int d;
        case ($urandom_range(0, 3))
            0: d = int'(tol);
            1: d = -int'(tol);
            default: d = int'($urandom_range(0, 2 * tol + 4)) - int'(tol) - 2;
        endcase
        return clamp_coord(center + d);
    endfunction

    function automatic int unsigned pick_tolerance();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return TOL_MAX;
            2: return $urandom_range(0, 63);
            default: return $urandom_range(0, TOL_MAX);
        endcase
    endfunction

    // Runs at the reset tolerance of 1.1875 on both axes.
    task automatic test_directed_basics();
        send_cmd(tca_pkg::FUNC_READ, 0, 0, 0, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 0, 0, 0, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 0, 19, -19, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 0, -19, 19, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 0, 20, 0, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 0, 0, -20, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 0, COORD_MAX, COORD_MIN, 63);
        send_cmd(tca_pkg::FUNC_PUSH, 0, COORD_MIN, COORD_MAX, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 0, COORD_MAX - 5, COORD_MIN + 19, 0);
        send_cmd(tca_pkg::FUNC_READ, 0, 0, 0, 0);
        send_cmd(tca_pkg::FUNC_READ, 0, 0, 0, 3);
        send_cmd(tca_pkg::FUNC_READ, 0, 0, 0, 4);
        send_cmd(tca_pkg::FUNC_READ, 0, COORD_MAX, COORD_MIN, 5);
        send_cmd(tca_pkg::FUNC_READ, 0, 0, 0, 63);
        send_cmd(FUNC_SPARE, 0, COORD_MAX, COORD_MAX, 63);
        send_cmd(FUNC_SPARE, 15, COORD_MIN, COORD_MIN, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 15, COORD_MIN, COORD_MIN, 0);
        send_cmd(tca_pkg::FUNC_CLEAR, 0, COORD_MAX, COORD_MIN, 63);
        send_cmd(tca_pkg::FUNC_READ, 0, 0, 0, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 0, 100, 100, 0);
        send_cmd(tca_pkg::FUNC_READ, 0, 0, 0, 0);
        send_cmd(tca_pkg::FUNC_READ, 15, 0, 0, 0);
        drain();
    endtask

    // Exact matching only; fills one table, then overflows it.
    task automatic test_table_full();
        write_tolerances(0, 0);
        send_cmd(tca_pkg::FUNC_CLEAR, 3, 0, 0, 0);
        for (int i = 0; i < ENTRIES; i++)
            send_cmd(tca_pkg::FUNC_PUSH, 3, i * 16 - 500, -i * 3, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 3, 7777, 7777, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 3, (ENTRIES - 1) * 16 - 500, -(ENTRIES - 1) * 3, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 3, 10 * 16 - 500, -30, 0);
        send_cmd(tca_pkg::FUNC_READ, 3, 0, 0, ENTRIES - 1);
        send_cmd(tca_pkg::FUNC_READ, 3, 0, 0, 0);
        send_cmd(FUNC_SPARE, 3, 0, 0, 0);
        send_cmd(tca_pkg::FUNC_CLEAR, 3, 0, 0, 0);
        send_cmd(tca_pkg::FUNC_PUSH, 3, 7777, 7777, 0);
        drain();
    endtask

    // Repeated merges into one entry, one series at each end of the value range.
    task automatic test_extreme_merges();
        send_cmd(tca_pkg::FUNC_CLEAR, 5, 0, 0, 0);
        send_cmd(tca_pkg::FUNC_CLEAR, 6, 0, 0, 0);
        repeat (MERGE_PUSHES) send_cmd(tca_pkg::FUNC_PUSH, 5, COORD_MIN, COORD_MAX, 0);
        repeat (MERGE_PUSHES) send_cmd(tca_pkg::FUNC_PUSH, 6, COORD_MAX, COORD_MIN, 0);
        send_cmd(tca_pkg::FUNC_READ, 5, 0, 0, 0);
        send_cmd(tca_pkg::FUNC_READ, 6, 0, 0, 0);
        drain();
    endtask

    task automatic test_random_clusters();
        int unsigned ptol;
        int unsigned vtol;
        int          first;
        int          span;
        int          series_sel;
        int          n;
        int          slot;
        int          roll;
        int          pos;
        int          value;
        int          ridx;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    ptol = 0;
                    vtol = TOL_MAX;
                end
                1:
                begin
                    ptol = TOL_MAX;
                    vtol = 0;
                end
                default:
                begin
                    ptol = pick_tolerance();
                    vtol = pick_tolerance();
                end
            endcase
            write_tolerances(ptol, vtol);
            first = $urandom_range(0, SERIES - 1);
            span = $urandom_range(1, 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                series_sel = (first + int'($urandom_range(0, span - 1))) % SERIES;
                n = fill[series_sel];
                roll = $urandom_range(0, 99);
                ridx = $urandom_range(0, 63);
                pos = random_coord();
                value = random_coord();
                if (roll < 40 && n > 0)
                begin
                    // Aim at a stored reference so that most of these merge.
                    slot = series_sel * ENTRIES + int'($urandom_range(0, n - 1));
                    pos = near(int'(ref_pos[slot]), ptol);
                    value = near(int'(ref_val[slot]), vtol);
                    send_cmd(tca_pkg::FUNC_PUSH, series_sel, pos, value, ridx);
                end
                else if (roll < 75)
                    send_cmd(tca_pkg::FUNC_PUSH, series_sel, pos, value, ridx);
                else if (roll < 93)
                begin
                    if (roll < 85 && n > 0)
                        ridx = $urandom_range(0, n - 1);
                    else if (roll < 88)
                        ridx = n % ENTRIES;
                    send_cmd(tca_pkg::FUNC_READ, series_sel, pos, value, ridx);
                end
                else if (roll < 97)
                    send_cmd(tca_pkg::FUNC_CLEAR, series_sel, pos, value, ridx);
                else
                    send_cmd(FUNC_SPARE, series_sel, pos, value, ridx);
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cmd.valid        <= 1'b0;
        cmd.func         <= tca_pkg::FUNC_PUSH;
        cmd.series       <= '0;
        cmd.sample_pos   <= '0;
        cmd.sample_value <= '0;
        cmd.read_index   <= '0;
        cfg.valid        <= 1'b0;
        cfg.index        <= tca_pkg::CFG_POS_TOL;
        cfg.data         <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_table_full();
        test_extreme_merges();
        test_random_clusters();

        drain();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/tca_pkg.sv
sv/tca_cmd_if.sv
sv/tca_rsp_if.sv
sv/tca_cfg_if.sv
sv/tca_ram.sv
sv/tolerance_cluster_accumulator_unit.sv
tb/sv/tb_tolerance_cluster_accumulator_unit.sv
